// File: hdl/rmlu_pkg.sv
package rmlu_pkg;

  // widths of the thread id and of the depth and waiter counters
  localparam int unsigned THREAD_ID_BITS = 8;
  localparam int unsigned COUNT_BITS     = 16;

  // configuration port
  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS  = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MUTEX_KIND    = 1'd0,
    CFG_ROBUST_ENABLE = 1'd1
  } cfg_index_t;

  // lock types
  typedef enum logic [1:0] {
    KIND_NORMAL     = 2'd0,
    KIND_ERRORCHECK = 2'd1,
    KIND_RECURSIVE  = 2'd2,
    KIND_UNUSED     = 2'd3
  } mutex_kind_t;

  // request codes
  typedef enum logic [2:0] {
    CMD_LOCK          = 3'd0,
    CMD_TRYLOCK       = 3'd1,
    CMD_TIMEDLOCK     = 3'd2,
    CMD_UNLOCK        = 3'd3,
    CMD_CONSISTENT    = 3'd4,
    CMD_WAITER_LEAVES = 3'd5,
    CMD_DESTROY       = 3'd6
  } cmd_t;

  // answer codes
  typedef enum logic [3:0] {
    ST_OK              = 4'd0,
    ST_OWNER_DEAD      = 4'd1,
    ST_NOT_RECOVERABLE = 4'd2,
    ST_BUSY            = 4'd3,
    ST_DEADLOCK        = 4'd4,
    ST_TIMED_OUT       = 4'd5,
    ST_MUST_WAIT       = 4'd6,
    ST_NOT_PERMITTED   = 4'd7,
    ST_INVALID         = 4'd8
  } status_t;

  // robust recovery state
  typedef enum logic [1:0] {
    REC_CONSISTENT      = 2'd0,
    REC_OWNER_DEAD      = 2'd1,
    REC_NOT_RECOVERABLE = 2'd2
  } recovery_t;

  typedef struct packed {
    logic [2:0]                cmd;
    logic [THREAD_ID_BITS-1:0] requester_id;
    logic                      owner_exited;
    logic                      deadline_expired;
  } req_t;

  typedef struct packed {
    logic [3:0]            status;
    logic                  wake_waiter;
    logic                  held;
    logic [COUNT_BITS-1:0] depth_now;
  } rsp_t;

endpackage

// File: hdl/robust_mutex_lock_unit.sv
// Lock unit for one POSIX-style robust mutex (normal, errorcheck or recursive
// type). Every request yields exactly one result. A request is taken every
// cycle while results are being taken. A request is held in the request
// register; when it moves on, the state is updated and the answer is captured
// in the result register, from which the result is offered. The unit holds
// at most two requests; only a stalled result output slows the input.
// Configuration is written through cfg_we, cfg_index (0 mutex_kind,
// 1 robust_enable) and cfg_data; the user must write it only while no request
// is in flight, as the unit itself does not enforce this.
module robust_mutex_lock_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rmlu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rmlu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rmlu_pkg::req_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rmlu_pkg::rsp_t                      out_data
);

  rmlu_pkg::req_t req;
  rmlu_pkg::rsp_t rsp;
  logic           req_valid;
  logic           req_take;

  // request register
  rmlu_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take)
  );

  // mutex state and decision logic
  rmlu_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .apply     (req_take),
    .rsp       (rsp)
  );

  // result register
  rmlu_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .rsp_valid (req_valid),
    .rsp       (rsp),
    .rsp_take  (req_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/rmlu_in_stage.sv
module rmlu_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rmlu_pkg::req_t in_data,
  output logic          req_valid,
  output rmlu_pkg::req_t req,
  input  logic          req_take
);

  rmlu_pkg::req_t req_reg;
  logic           valid_reg;

  // the register can load when empty or when its request moves on this cycle
  assign in_ready  = !valid_reg || req_take;
  assign req_valid = valid_reg;
  assign req       = req_reg;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_reg <= 1'b0;
    end else if (in_ready) begin
      valid_reg <= in_valid;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_reg <= in_data;
    end
  end

endmodule

// File: hdl/rmlu_core.sv
module rmlu_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rmlu_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rmlu_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  rmlu_pkg::req_t                       req,
  input  logic                                 apply,
  output rmlu_pkg::rsp_t                       rsp
);

  localparam int unsigned IDB = rmlu_pkg::THREAD_ID_BITS;
  localparam int unsigned CB  = rmlu_pkg::COUNT_BITS;

  // configuration
  rmlu_pkg::mutex_kind_t mutex_kind;
  logic                  robust_enable;

  // mutex state
  logic                alive, alive_next;
  logic                owner_valid, owner_valid_next;
  logic [IDB-1:0]      owner_thread, owner_thread_next;
  logic [CB-1:0]       depth_count, depth_count_next;
  logic [CB-1:0]       waiter_count, waiter_count_next;
  rmlu_pkg::recovery_t recovery_state, recovery_state_next;

  rmlu_pkg::status_t status;
  logic              wake;
  logic              is_owner;
  logic              strict;
  logic              od_state;
  logic [CB-1:0]     depth_dec;
  logic [CB-1:0]     waiter_inc;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mutex_kind    <= rmlu_pkg::KIND_NORMAL;
      robust_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (rmlu_pkg::cfg_index_t'(cfg_index))
        rmlu_pkg::CFG_MUTEX_KIND:    mutex_kind <= rmlu_pkg::mutex_kind_t'(cfg_data[1:0]);
        rmlu_pkg::CFG_ROBUST_ENABLE: robust_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shared terms
  assign is_owner   = owner_valid && (owner_thread == req.requester_id);
  assign strict     = (mutex_kind == rmlu_pkg::KIND_ERRORCHECK) ||
                      (mutex_kind == rmlu_pkg::KIND_RECURSIVE) || robust_enable;
  assign od_state   = robust_enable && (recovery_state == rmlu_pkg::REC_OWNER_DEAD);
  assign depth_dec  = (depth_count != '0) ? depth_count - CB'(1) : '0;
  assign waiter_inc = (waiter_count != '1) ? waiter_count + CB'(1) : waiter_count;

  // request decode and next state
  always_comb begin
    alive_next          = alive;
    owner_valid_next    = owner_valid;
    owner_thread_next   = owner_thread;
    depth_count_next    = depth_count;
    waiter_count_next   = waiter_count;
    recovery_state_next = recovery_state;
    status              = rmlu_pkg::ST_INVALID;
    wake                = 1'b0;
    if (alive) begin
      unique case (req.cmd)
        rmlu_pkg::CMD_LOCK, rmlu_pkg::CMD_TRYLOCK, rmlu_pkg::CMD_TIMEDLOCK: begin
          priority if (robust_enable && owner_valid && req.owner_exited) begin
            // owner died: take over
            owner_thread_next   = req.requester_id;
            depth_count_next    = CB'(1);
            recovery_state_next = rmlu_pkg::REC_OWNER_DEAD;
            status              = rmlu_pkg::ST_OWNER_DEAD;
          end else if (!owner_valid) begin
            if (robust_enable &&
                recovery_state == rmlu_pkg::REC_NOT_RECOVERABLE) begin
              status = rmlu_pkg::ST_NOT_RECOVERABLE;
            end else begin
              owner_valid_next  = 1'b1;
              owner_thread_next = req.requester_id;
              depth_count_next  = CB'(1);
              status = od_state ? rmlu_pkg::ST_OWNER_DEAD : rmlu_pkg::ST_OK;
            end
          end else if (is_owner && mutex_kind == rmlu_pkg::KIND_RECURSIVE) begin
            // recursive relock, saturating
            if (depth_count != '1) begin
              depth_count_next = depth_count + CB'(1);
            end
            status = rmlu_pkg::ST_OK;
          end else if (is_owner && mutex_kind == rmlu_pkg::KIND_ERRORCHECK &&
                       req.cmd != rmlu_pkg::CMD_TRYLOCK) begin
            status = rmlu_pkg::ST_DEADLOCK;
          end else if (req.cmd == rmlu_pkg::CMD_TRYLOCK) begin
            status = rmlu_pkg::ST_BUSY;
          end else if (req.cmd == rmlu_pkg::CMD_TIMEDLOCK && req.deadline_expired) begin
            status = rmlu_pkg::ST_TIMED_OUT;
          end else begin
            waiter_count_next = waiter_inc;
            status            = rmlu_pkg::ST_MUST_WAIT;
          end
        end
        rmlu_pkg::CMD_UNLOCK: begin
          if (!is_owner && strict) begin
            status = rmlu_pkg::ST_NOT_PERMITTED;
          end else begin
            depth_count_next = depth_dec;
            if (depth_dec == '0) begin
              if (od_state) begin
                recovery_state_next = rmlu_pkg::REC_NOT_RECOVERABLE;
              end
              owner_valid_next  = 1'b0;
              owner_thread_next = '0;
              wake              = (waiter_count != '0);
            end
            status = rmlu_pkg::ST_OK;
          end
        end
        rmlu_pkg::CMD_CONSISTENT: begin
          if (od_state && is_owner) begin
            recovery_state_next = rmlu_pkg::REC_CONSISTENT;
            status              = rmlu_pkg::ST_OK;
          end
        end
        rmlu_pkg::CMD_WAITER_LEAVES: begin
          if (waiter_count != '0) begin
            waiter_count_next = waiter_count - CB'(1);
          end
          status = rmlu_pkg::ST_OK;
        end
        rmlu_pkg::CMD_DESTROY: begin
          if (owner_valid || waiter_count != '0) begin
            status = rmlu_pkg::ST_BUSY;
          end else begin
            alive_next = 1'b0;
            status     = rmlu_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // state update when a request passes to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      alive          <= 1'b1;
      owner_valid    <= 1'b0;
      owner_thread   <= '0;
      depth_count    <= '0;
      waiter_count   <= '0;
      recovery_state <= rmlu_pkg::REC_CONSISTENT;
    end else if (apply) begin
      alive          <= alive_next;
      owner_valid    <= owner_valid_next;
      owner_thread   <= owner_thread_next;
      depth_count    <= depth_count_next;
      waiter_count   <= waiter_count_next;
      recovery_state <= recovery_state_next;
    end
  end

  // result of this request
  assign rsp.status      = status;
  assign rsp.wake_waiter = wake;
  assign rsp.held        = owner_valid_next;
  assign rsp.depth_now   = depth_count_next;

endmodule

// File: hdl/rmlu_out_stage.sv
module rmlu_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           rsp_valid,
  input  rmlu_pkg::rsp_t rsp,
  output logic           rsp_take,
  output logic           out_valid,
  input  logic           out_ready,
  output rmlu_pkg::rsp_t out_data
);

  rmlu_pkg::rsp_t data_reg;
  logic           valid_reg;

  // the result register frees up when empty or when its result transfers
  assign rsp_take  = rsp_valid && (!valid_reg || out_ready);
  assign out_valid = valid_reg;
  assign out_data  = data_reg;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_reg <= 1'b0;
    end else if (!valid_reg || out_ready) begin
      valid_reg <= rsp_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (rsp_take) begin
      data_reg <= rsp;
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned IDB          = rmlu_pkg::THREAD_ID_BITS;
  localparam int unsigned CB           = rmlu_pkg::COUNT_BITS;
  localparam int unsigned CYCLE_LIMIT  = 50000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PRINT_LIMIT  = 50;
  localparam int unsigned RANDOM_CHUNK = 65;
  localparam logic [2:0]  CMD_UNUSED   = 3'd7;

  // requester ids used by the directed tests
  localparam logic [IDB-1:0] THREAD_A = 8'd17;
  localparam logic [IDB-1:0] THREAD_B = 8'd42;
  localparam logic [IDB-1:0] THREAD_C = 8'd0;
  localparam logic [IDB-1:0] THREAD_D = 8'd255;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  rmlu_pkg::cfg_index_t cfg_index = rmlu_pkg::CFG_MUTEX_KIND;
  logic [rmlu_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  rmlu_pkg::req_t       in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rmlu_pkg::rsp_t       out_data;

  // mirror of the lock unit state and its configuration
  rmlu_pkg::mutex_kind_t model_kind;
  logic                  model_robust;
  logic                  lock_alive;
  logic                  lock_owned;
  logic [IDB-1:0]        lock_owner;
  logic [CB-1:0]         lock_depth;
  logic [CB-1:0]         lock_waiters;
  rmlu_pkg::recovery_t   lock_recovery;

  rmlu_pkg::rsp_t pending_answers[$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    hold_requests = 0;

  robust_mutex_lock_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // expected answer for one request, updating the mirrored state
  function automatic rmlu_pkg::rsp_t predict_answer(input rmlu_pkg::req_t req);
    rmlu_pkg::rsp_t    ans;
    rmlu_pkg::status_t st;
    logic              wake;
    logic              is_owner;
    st = rmlu_pkg::ST_INVALID;
    wake = 1'b0;
    is_owner = lock_owned && lock_owner == req.requester_id;
    if (lock_alive) begin
      case (req.cmd)
        rmlu_pkg::CMD_LOCK, rmlu_pkg::CMD_TRYLOCK, rmlu_pkg::CMD_TIMEDLOCK: begin
          if (model_robust && lock_owned && req.owner_exited) begin
            // takeover from an exited owner
            lock_owner = req.requester_id;
            lock_depth = CB'(1);
            lock_recovery = rmlu_pkg::REC_OWNER_DEAD;
            st = rmlu_pkg::ST_OWNER_DEAD;
          end else if (!lock_owned) begin
            if (model_robust && lock_recovery == rmlu_pkg::REC_NOT_RECOVERABLE) begin
              st = rmlu_pkg::ST_NOT_RECOVERABLE;
            end else begin
              lock_owned = 1'b1;
              lock_owner = req.requester_id;
              lock_depth = CB'(1);
              st = (model_robust && lock_recovery == rmlu_pkg::REC_OWNER_DEAD) ?
                   rmlu_pkg::ST_OWNER_DEAD : rmlu_pkg::ST_OK;
            end
          end else if (is_owner && model_kind == rmlu_pkg::KIND_RECURSIVE) begin
            if (lock_depth != '1) lock_depth = lock_depth + CB'(1);
            st = rmlu_pkg::ST_OK;
          end else if (is_owner && (model_kind == rmlu_pkg::KIND_ERRORCHECK ||
                                    req.cmd == rmlu_pkg::CMD_TRYLOCK)) begin
            st = (req.cmd == rmlu_pkg::CMD_TRYLOCK) ? rmlu_pkg::ST_BUSY : rmlu_pkg::ST_DEADLOCK;
          end else if (req.cmd == rmlu_pkg::CMD_TRYLOCK) begin
            st = rmlu_pkg::ST_BUSY;
          end else if (req.cmd == rmlu_pkg::CMD_TIMEDLOCK && req.deadline_expired) begin
            st = rmlu_pkg::ST_TIMED_OUT;
          end else begin
            if (lock_waiters != '1) lock_waiters = lock_waiters + CB'(1);
            st = rmlu_pkg::ST_MUST_WAIT;
          end
        end
        rmlu_pkg::CMD_UNLOCK: begin
          if (!is_owner && (model_kind == rmlu_pkg::KIND_ERRORCHECK ||
                            model_kind == rmlu_pkg::KIND_RECURSIVE || model_robust)) begin
            st = rmlu_pkg::ST_NOT_PERMITTED;
          end else begin
            // depth never wraps below zero
            if (lock_depth != '0) lock_depth = lock_depth - CB'(1);
            if (lock_depth == '0) begin
              if (model_robust && lock_recovery == rmlu_pkg::REC_OWNER_DEAD)
                lock_recovery = rmlu_pkg::REC_NOT_RECOVERABLE;
              lock_owned = 1'b0;
              lock_owner = '0;
              wake = (lock_waiters != '0);
            end
            st = rmlu_pkg::ST_OK;
          end
        end
        rmlu_pkg::CMD_CONSISTENT: begin
          if (model_robust && is_owner && lock_recovery == rmlu_pkg::REC_OWNER_DEAD) begin
            lock_recovery = rmlu_pkg::REC_CONSISTENT;
            st = rmlu_pkg::ST_OK;
          end
        end
        rmlu_pkg::CMD_WAITER_LEAVES: begin
          if (lock_waiters != '0) lock_waiters = lock_waiters - CB'(1);
          st = rmlu_pkg::ST_OK;
        end
        rmlu_pkg::CMD_DESTROY: begin
          if (lock_owned || lock_waiters != '0) begin
            st = rmlu_pkg::ST_BUSY;
          end else begin
            lock_alive = 1'b0;
            st = rmlu_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
    ans.status = st;
    ans.wake_waiter = wake;
    ans.held = lock_owned;
    ans.depth_now = lock_depth;
    return ans;
  endfunction

  function automatic rmlu_pkg::req_t make_req(input logic [2:0] cmd, input logic [IDB-1:0] id,
                                              input logic exited = 1'b0,
                                              input logic expired = 1'b0);
    rmlu_pkg::req_t r;
    r.cmd = cmd;
    r.requester_id = id;
    r.owner_exited = exited;
    r.deadline_expired = expired;
    return r;
  endfunction

  // mostly plausible traffic from a few threads, with some noise
  function automatic rmlu_pkg::req_t random_request();
    rmlu_pkg::req_t r;
    int             pick;
    r.requester_id = ($urandom_range(0, 9) == 0) ? IDB'($urandom) :
                                                    IDB'($urandom_range(0, 3));
    r.owner_exited = ($urandom_range(0, 9) == 0);
    r.deadline_expired = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 20)      r.cmd = rmlu_pkg::CMD_LOCK;
    else if (pick < 32) r.cmd = rmlu_pkg::CMD_TRYLOCK;
    else if (pick < 47) r.cmd = rmlu_pkg::CMD_TIMEDLOCK;
    else if (pick < 70) r.cmd = rmlu_pkg::CMD_UNLOCK;
    else if (pick < 78) r.cmd = rmlu_pkg::CMD_CONSISTENT;
    else if (pick < 90) r.cmd = rmlu_pkg::CMD_WAITER_LEAVES;
    else if (pick < 95) r.cmd = rmlu_pkg::CMD_DESTROY;
    else                r.cmd = CMD_UNUSED;
    if ((r.cmd == rmlu_pkg::CMD_UNLOCK || r.cmd == rmlu_pkg::CMD_CONSISTENT) && lock_owned &&
        $urandom_range(0, 3) != 0)
      r.requester_id = lock_owner;
    // an owner-dead mutex is often repaired by its new owner
    if (model_robust && lock_owned && lock_recovery == rmlu_pkg::REC_OWNER_DEAD &&
        $urandom_range(0, 2) == 0) begin
      r.cmd = rmlu_pkg::CMD_CONSISTENT;
      r.requester_id = lock_owner;
    end
    // a destroy that succeeds would end the useful part of the run
    if (r.cmd == rmlu_pkg::CMD_DESTROY && !lock_owned && lock_waiters == '0)
      r.cmd = rmlu_pkg::CMD_LOCK;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // one request transfer, with random gaps in front of it
  task automatic issue_request(input rmlu_pkg::req_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_answers.push_back(predict_answer(req));
  endtask

  task automatic wait_for_answers();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input rmlu_pkg::cfg_index_t idx,
                              input logic [rmlu_pkg::CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == rmlu_pkg::CFG_MUTEX_KIND) model_kind = rmlu_pkg::mutex_kind_t'(value);
    else model_robust = value[0];
  endtask

  // drain, then set lock type and robust mode (upper data bit is don't-care for robust)
  task automatic configure_lock(input rmlu_pkg::mutex_kind_t kind, input logic robust);
    wait_for_answers();
    write_config(rmlu_pkg::CFG_MUTEX_KIND, kind);
    write_config(rmlu_pkg::CFG_ROBUST_ENABLE, {1'($urandom), robust});
  endtask

  // bring a not-recoverable mutex back to a consistent, free state
  task automatic recover_mutex(input rmlu_pkg::mutex_kind_t kind);
    configure_lock(kind, 1'b0);
    if (!lock_owned) issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_A));
    configure_lock(kind, 1'b1);
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_B, 1'b1));
    issue_request(make_req(rmlu_pkg::CMD_CONSISTENT, THREAD_B));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_B));
  endtask

  // free the mutex and send every waiter away
  task automatic clear_mutex();
    configure_lock(rmlu_pkg::KIND_NORMAL, 1'b0);
    while (lock_owned) issue_request(make_req(rmlu_pkg::CMD_UNLOCK, lock_owner));
    while (lock_waiters != '0) issue_request(make_req(rmlu_pkg::CMD_WAITER_LEAVES, THREAD_A));
  endtask

  task automatic test_normal_mutex();
    configure_lock(rmlu_pkg::KIND_NORMAL, 1'b0);
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_C));
    issue_request(make_req(rmlu_pkg::CMD_TRYLOCK, THREAD_D));
    issue_request(make_req(rmlu_pkg::CMD_TIMEDLOCK, THREAD_D, 1'b0, 1'b1));
    issue_request(make_req(rmlu_pkg::CMD_TIMEDLOCK, THREAD_D));
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_C));
    issue_request(make_req(rmlu_pkg::CMD_TIMEDLOCK, THREAD_C, 1'b1, 1'b1));
    issue_request(make_req(rmlu_pkg::CMD_TRYLOCK, THREAD_C));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_D));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_D));
    repeat (3) issue_request(make_req(rmlu_pkg::CMD_WAITER_LEAVES, THREAD_C));
    issue_request(make_req(rmlu_pkg::CMD_CONSISTENT, THREAD_C));
    issue_request(make_req(CMD_UNUSED, THREAD_D, 1'b1, 1'b1));
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_D));
    issue_request(make_req(rmlu_pkg::CMD_DESTROY, THREAD_D));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_D));
  endtask

  task automatic test_checked_kinds();
    // errorcheck: self relock and foreign unlock are refused
    configure_lock(rmlu_pkg::KIND_ERRORCHECK, 1'b0);
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_TRYLOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_TIMEDLOCK, THREAD_A, 1'b0, 1'b1));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_B));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_A));
    // recursive: relock counts up
    configure_lock(rmlu_pkg::KIND_RECURSIVE, 1'b0);
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_TIMEDLOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_TRYLOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_B));
    repeat (3) issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_A));
    // unused kind code acts as normal
    configure_lock(rmlu_pkg::KIND_UNUSED, 1'b0);
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_B));
    issue_request(make_req(rmlu_pkg::CMD_WAITER_LEAVES, THREAD_B));
  endtask

  task automatic test_robust_recovery();
    configure_lock(rmlu_pkg::KIND_NORMAL, 1'b1);
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_B));
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_B, 1'b1));
    issue_request(make_req(rmlu_pkg::CMD_CONSISTENT, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_CONSISTENT, THREAD_B));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_B));
    // takeover by the dead owner's own id, then unlock without repair
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_TIMEDLOCK, THREAD_A, 1'b1));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_B));
    issue_request(make_req(rmlu_pkg::CMD_TRYLOCK, THREAD_B));
    issue_request(make_req(rmlu_pkg::CMD_CONSISTENT, THREAD_B));
    recover_mutex(rmlu_pkg::KIND_ERRORCHECK);
    // owner-dead state left on a free mutex while robust mode was off
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_TRYLOCK, THREAD_B, 1'b1));
    configure_lock(rmlu_pkg::KIND_NORMAL, 1'b0);
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_B));
    configure_lock(rmlu_pkg::KIND_NORMAL, 1'b1);
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_CONSISTENT, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_A));
  endtask

  task automatic test_random_traffic();
    rmlu_pkg::mutex_kind_t chunk_kind [6] = '{rmlu_pkg::KIND_NORMAL, rmlu_pkg::KIND_ERRORCHECK,
                                             rmlu_pkg::KIND_RECURSIVE, rmlu_pkg::KIND_UNUSED,
                                             rmlu_pkg::KIND_RECURSIVE, rmlu_pkg::KIND_NORMAL};
    logic                  chunk_robust [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    for (int chunk = 0; chunk < 6; chunk++) begin
      // idling: sender light and receiver heavy, then the reverse, then none
      case (chunk / 2)
        0: begin send_idle_pct = 6;  recv_idle_pct = 52; end
        1: begin send_idle_pct = 52; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      configure_lock(chunk_kind[chunk], chunk_robust[chunk]);
      for (int n = 0; n < RANDOM_CHUNK; n++) begin
        if (model_robust && !lock_owned && lock_recovery == rmlu_pkg::REC_NOT_RECOVERABLE)
          recover_mutex(chunk_kind[chunk]);
        issue_request(random_request());
      end
    end
  endtask

  // receiver held off for a long stretch while requests keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure_lock(rmlu_pkg::KIND_RECURSIVE, 1'b0);
    hold_requests++;
    repeat (40) issue_request(random_request());
    wait_for_answers();
  endtask

  task automatic test_destroy();
    send_idle_pct = 6;
    recv_idle_pct = 52;
    clear_mutex();
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_DESTROY, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_UNLOCK, THREAD_A));
    issue_request(make_req(rmlu_pkg::CMD_DESTROY, THREAD_A));
    // everything after a destroy is refused
    for (int c = 0; c < 8; c++) issue_request(make_req(3'(c), THREAD_D, 1'b1, 1'b1));
    configure_lock(rmlu_pkg::KIND_UNUSED, 1'b1);
    issue_request(make_req(rmlu_pkg::CMD_LOCK, THREAD_A, 1'b1));
  endtask

  // receiver: random stalls, or a long hold when one is requested
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // compare each result transfer with the oldest expected answer
  always @(posedge clk) begin
    rmlu_pkg::rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_answers.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_data.status, want.status));
        if (out_data.wake_waiter !== want.wake_waiter)
          report_mismatch($sformatf("wake_waiter %0b, expected %0b", out_data.wake_waiter,
                                    want.wake_waiter));
        if (out_data.held !== want.held)
          report_mismatch($sformatf("held %0b, expected %0b", out_data.held, want.held));
        if (out_data.depth_now !== want.depth_now)
          report_mismatch($sformatf("depth_now %0d, expected %0d", out_data.depth_now,
                                    want.depth_now));
      end
    end
  end

  initial begin
    model_kind    = rmlu_pkg::KIND_NORMAL;
    model_robust  = 1'b0;
    lock_alive    = 1'b1;
    lock_owned    = 1'b0;
    lock_owner    = '0;
    lock_depth    = '0;
    lock_waiters  = '0;
    lock_recovery = rmlu_pkg::REC_CONSISTENT;
    send_idle_pct = 6;
    recv_idle_pct = 52;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_normal_mutex();
    test_checked_kinds();
    test_robust_recovery();
    test_random_traffic();
    test_backpressure();
    test_destroy();
    wait_for_answers();

    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: robust_mutex_lock_unit.f
hdl/rmlu_pkg.sv
hdl/rmlu_in_stage.sv
hdl/rmlu_core.sv
hdl/rmlu_out_stage.sv
hdl/robust_mutex_lock_unit.sv
tb/sv/testbench.sv
